[hdl/clst_pkg.sv]
// Shared constants, types and helpers of the circular list engine.
`timescale 1ns / 1ps

package clst_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int CMP_W    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FIRST = 3'd3,
        OP_DEL_LAST  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [POS_W-1:0]        pos_t;

    // Store access issued by the sequencer
    typedef struct packed {
        slot_t  rd_addr;
        logic   val_we;
        slot_t  val_addr;
        value_t val_data;
        logic   lnk_we;
        slot_t  lnk_addr;
        slot_t  lnk_data;
    } mem_req_t;

    // Registered read data of the store
    typedef struct packed {
        value_t value;
        slot_t  link;
    } mem_rsp_t;

    typedef struct packed {
        status_t status;
        logic    found;
        cnt_t    count;
    } result_t;

    // Lowest slot whose used bit is clear
    function automatic slot_t first_free(input logic [CAPACITY-1:0] used);
        slot_t s;
        s = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!used[i]) begin
                s = slot_t'(i);
            end
        end
        return s;
    endfunction

endpackage

[hdl/clst_req_if.sv]
// Request channel of the circular list engine.
`timescale 1ns / 1ps

interface clst_req_if;
    logic                  valid;
    logic                  ready;
    logic [2:0]            operation;
    logic signed [31:0]    value;
    logic [7:0]            position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

[hdl/clst_rsp_if.sv]
// Result channel of the circular list engine.
`timescale 1ns / 1ps

interface clst_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       found;
    logic [4:0] entry_count;

    modport source (output valid, output status, output found, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found, input entry_count,
                    output ready);
endinterface

[hdl/clst_store.sv]
// Node store: value memory and link memory, one write and one registered read each.
`timescale 1ns / 1ps

module clst_store (
    input  logic                clk,
    input  clst_pkg::mem_req_t  mem_req,
    output clst_pkg::mem_rsp_t  mem_rsp
);
    import clst_pkg::*;

    value_t val_mem [CAPACITY];
    slot_t  lnk_mem [CAPACITY];

    // Write value and link entries
    always_ff @(posedge clk)
    begin
        if (mem_req.val_we)
        begin
            val_mem[mem_req.val_addr] <= mem_req.val_data;
        end
        if (mem_req.lnk_we)
        begin
            lnk_mem[mem_req.lnk_addr] <= mem_req.lnk_data;
        end
    end

    // Read both memories at the same slot into registered outputs
    always_ff @(posedge clk)
    begin
        mem_rsp.value <= val_mem[mem_req.rd_addr];
        mem_rsp.link  <= lnk_mem[mem_req.rd_addr];
    end

endmodule

[hdl/clst_seq.sv]
// Sequencer: decodes requests, walks the ring and updates links, head and count.
`timescale 1ns / 1ps

module clst_seq (
    input  logic               clk,
    input  logic               rst_n,
    clst_req_if.sink           req,
    output clst_pkg::mem_req_t mem_req,
    input  clst_pkg::mem_rsp_t mem_rsp,
    output logic               res_valid,
    input  logic               res_ready,
    output clst_pkg::result_t  res
);
    import clst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_FIX,
        S_DEL_FIX,
        S_SRCH,
        S_RESULT
    } state_t;

    state_t                state_reg;
    logic [CAPACITY-1:0]   used_reg;
    slot_t                 head_reg;
    cnt_t                  count_reg;
    cnt_t                  left_reg;
    slot_t                 node_reg;
    slot_t                 new_reg;
    slot_t                 tgt_reg;
    value_t                value_reg;
    logic                  is_ins_reg;
    logic                  idx0_reg;
    status_t               status_reg;
    logic                  found_reg;

    logic                  acc;
    op_t                   op;
    slot_t                 free;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    cnt_t                  pos_idx;
    cnt_t                  idx;
    cnt_t                  walk_k;
    status_t               dec_status;
    logic                  dec_ins;
    logic                  dec_del;
    logic                  dec_search;
    logic                  ins_go;
    logic                  del_go;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign op        = op_t'(req.operation);
    assign free      = first_free(used_reg);
    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_idx   = cnt_t'(pos_ext - CMP_W'(1));
    assign walk_k    = (idx == '0) ? cnt_t'(count_reg - cnt_t'(1)) : cnt_t'(idx - cnt_t'(1));
    assign ins_go    = dec_ins && (dec_status == ST_OK);
    assign del_go    = dec_del && (dec_status == ST_OK);

    // Decode the request against the current count
    always_comb
    begin
        dec_status = ST_OK;
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_search = 1'b0;
        idx        = '0;
        unique case (op)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
            begin
                dec_ins = 1'b1;
                if (count_reg >= cnt_t'(CAPACITY))
                begin
                    dec_status = ST_FULL;
                end
                else if (op == OP_INS_LAST)
                begin
                    idx = count_reg;
                end
                else if (op == OP_INS_AT)
                begin
                    if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                    begin
                        dec_status = ST_BAD_POS;
                    end
                    idx = pos_idx;
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
            begin
                dec_del = 1'b1;
                if (count_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (op == OP_DEL_LAST)
                begin
                    idx = cnt_t'(count_reg - cnt_t'(1));
                end
                else if (op == OP_DEL_AT)
                begin
                    if (pos_ext == '0 || pos_ext > cnt_ext)
                    begin
                        dec_status = ST_BAD_POS;
                    end
                    idx = pos_idx;
                end
            end
            OP_SEARCH:
            begin
                dec_search = 1'b1;
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    // Drive store reads and writes
    always_comb
    begin
        mem_req          = '0;
        mem_req.rd_addr  = (state_reg == S_IDLE) ? head_reg : mem_rsp.link;
        mem_req.val_addr = free;
        mem_req.val_data = req.value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && ins_go)
                begin
                    mem_req.val_we = 1'b1;
                    if (count_reg == '0)
                    begin
                        mem_req.lnk_we   = 1'b1;
                        mem_req.lnk_addr = free;
                        mem_req.lnk_data = free;
                    end
                end
            end
            S_WALK:
            begin
                if (left_reg == '0 && is_ins_reg)
                begin
                    mem_req.lnk_we   = 1'b1;
                    mem_req.lnk_addr = new_reg;
                    mem_req.lnk_data = mem_rsp.link;
                end
            end
            S_INS_FIX:
            begin
                mem_req.lnk_we   = 1'b1;
                mem_req.lnk_addr = node_reg;
                mem_req.lnk_data = new_reg;
            end
            S_DEL_FIX:
            begin
                mem_req.lnk_we   = 1'b1;
                mem_req.lnk_addr = node_reg;
                mem_req.lnk_data = mem_rsp.link;
            end
            default:
            begin
                mem_req.lnk_we = 1'b0;
            end
        endcase
    end

    assign res_valid  = (state_reg == S_RESULT);
    assign res.status = status_reg;
    assign res.found  = found_reg;
    assign res.count  = count_reg;

    // Hold state, list bookkeeping and the pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            left_reg   <= '0;
            node_reg   <= '0;
            new_reg    <= '0;
            tgt_reg    <= '0;
            value_reg  <= '0;
            is_ins_reg <= 1'b0;
            idx0_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        value_reg  <= req.value;
                        new_reg    <= free;
                        node_reg   <= head_reg;
                        left_reg   <= dec_search ? count_reg : walk_k;
                        is_ins_reg <= dec_ins;
                        idx0_reg   <= (idx == '0);
                        status_reg <= dec_status;
                        found_reg  <= 1'b0;
                        state_reg  <= S_RESULT;
                        if (ins_go && count_reg == '0)
                        begin
                            // first node forms a ring of one
                            used_reg[free] <= 1'b1;
                            head_reg       <= free;
                            count_reg      <= cnt_t'(1);
                        end
                        else if (del_go && count_reg == cnt_t'(1))
                        begin
                            used_reg[head_reg] <= 1'b0;
                            count_reg          <= '0;
                        end
                        else if (ins_go || del_go)
                        begin
                            state_reg <= S_WALK;
                        end
                        else if (dec_search && count_reg != '0)
                        begin
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_WALK:
                begin
                    // node_reg is the predecessor once no steps remain
                    if (left_reg == '0)
                    begin
                        if (is_ins_reg)
                        begin
                            state_reg <= S_INS_FIX;
                        end
                        else
                        begin
                            tgt_reg   <= mem_rsp.link;
                            state_reg <= S_DEL_FIX;
                        end
                    end
                    else
                    begin
                        node_reg <= mem_rsp.link;
                        left_reg <= cnt_t'(left_reg - cnt_t'(1));
                    end
                end
                S_INS_FIX:
                begin
                    used_reg[new_reg] <= 1'b1;
                    count_reg         <= cnt_t'(count_reg + cnt_t'(1));
                    if (idx0_reg)
                    begin
                        head_reg <= new_reg;
                    end
                    state_reg <= S_RESULT;
                end
                S_DEL_FIX:
                begin
                    used_reg[tgt_reg] <= 1'b0;
                    count_reg         <= cnt_t'(count_reg - cnt_t'(1));
                    if (idx0_reg)
                    begin
                        head_reg <= mem_rsp.link;
                    end
                    state_reg <= S_RESULT;
                end
                S_SRCH:
                begin
                    if (mem_rsp.value == value_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_RESULT;
                    end
                    else if (left_reg == cnt_t'(1))
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        left_reg <= cnt_t'(left_reg - cnt_t'(1));
                    end
                end
                S_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/circular_list_engine_core.sv]
// Top level of the circular list engine: sequencer, node store and result register.
`timescale 1ns / 1ps
//
// Keeps an ordered ring of up to 16 signed 32-bit values as a singly linked
// list in a node store. Requests arrive on req (operation, value, position)
// and each one yields exactly one transfer on rsp (status, found,
// entry_count). Both channels transfer when valid and ready are high.
//
// One request is worked on at a time. The store has one read port with
// registered read data, so a walk follows the links one after another.
// A new request is taken as soon as the previous result sits in the output
// register, even if the receiver has not taken it yet; while the receiver
// stalls a second result waits in the sequencer and req stays not ready.
// Reset (rst_n low, asynchronous) empties the list; the store contents are
// not cleared and no clearing pass is needed.
//

module circular_list_engine_core (
    input  logic     clk,
    input  logic     rst_n,
    clst_req_if.sink req,
    clst_rsp_if.source rsp
);
    import clst_pkg::*;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     out_valid_reg;
    result_t  out_reg;

    clst_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    clst_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = ST_W'(out_reg.status);
    assign rsp.found       = out_reg.found;
    assign rsp.entry_count = out_reg.count;

endmodule

[hdl/clst_checker.sv]
// Port-level assertions for the circular list engine, bound to the top level.
`timescale 1ns / 1ps

module clst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic       rsp_found,
    input logic [4:0] rsp_entry_count
);
    import clst_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_found) && $stable(rsp_entry_count))
        else $error("stalled result changed");

    // Full is only reported with every slot held
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == 5'(CAPACITY))
        else $error("full reported below capacity");

    // Underflow is only reported on an empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0)
        else $error("underflow reported on non-empty list");

    // A hit needs a successful request on a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_status == ST_OK && rsp_entry_count != '0)
        else $error("found with bad status or empty list");

    // Count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= 5'(CAPACITY))
        else $error("entry count above capacity");

endmodule

bind circular_list_engine_core clst_checker u_clst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found       (rsp.found),
    .rsp_entry_count (rsp.entry_count)
);
